/* rtl/core/ssco_pkg.sv */
package ssco_pkg;
  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_WIDTH   = 36;
  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 2;
  localparam int MW  = 2 * SW;
  localparam int QW  = FRAC_BITS + 1;
  localparam int HW  = SW / 2;
  localparam int UD  = FRAC_BITS + 8;
  localparam int NSTG = FRAC_BITS + 11;
  localparam int IN_BITS  = 12 * COORD_WIDTH;
  localparam int OUT_BITS = ((3 * OUT_WIDTH + 7) / 8) * 8;

  typedef logic signed [DW-1:0] crd_t;

  typedef struct packed {
    crd_t [2:0] u;
    crd_t [2:0] v;
    crd_t [2:0] w;
  } uvw_t;

  typedef struct packed {
    logic signed [SW-1:0] a;
    logic signed [SW-1:0] b;
    logic signed [SW-1:0] c;
    logic signed [SW-1:0] d;
    logic signed [SW-1:0] e;
  } dot_t;

  typedef struct packed {
    logic signed [MW-1:0] sn;
    logic signed [MW-1:0] sd;
    logic signed [MW-1:0] tn;
    logic signed [MW-1:0] td;
  } frac_t;
endpackage

/* rtl/core/ssco_mul.sv */
module ssco_mul (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [ssco_pkg::SW-1:0] a,
  input  logic signed [ssco_pkg::SW-1:0] b,
  output logic signed [ssco_pkg::MW-1:0] p
);
  localparam int HW = ssco_pkg::HW;
  localparam int SW = ssco_pkg::SW;
  localparam int MW = ssco_pkg::MW;

  logic signed [SW+HW-1:0] ph_r;
  logic signed [SW+HW:0]   pl_r;
  logic signed [MW-1:0]    p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r <= a * $signed(b[SW-1:HW]);
      pl_r <= a * $signed({1'b0, b[HW-1:0]});
      p_r  <= $signed({ph_r, {HW{1'b0}}}) + MW'(pl_r);
    end
  end

  assign p = p_r;
endmodule

/* rtl/core/ssco_div.sv */
module ssco_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [ssco_pkg::MW-1:0] num,
  input  logic signed [ssco_pkg::MW-1:0] den,
  output logic        [ssco_pkg::QW-1:0] q
);
  localparam int MW = ssco_pkg::MW;
  localparam int QW = ssco_pkg::QW;
  localparam int FB = ssco_pkg::FRAC_BITS;

  logic [MW-1:0] r_r   [FB+1];
  logic [MW-1:0] d_r   [FB+1];
  logic [QW-1:0] q_r   [FB+1];
  logic          done_r[FB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0] <= num;
      d_r[0] <= den;
      if (num <= 0 || den <= 0) begin
        done_r[0] <= 1'b1;
        q_r[0]    <= '0;
      end else if (num >= den) begin
        done_r[0] <= 1'b1;
        q_r[0]    <= QW'(1) << FB;
      end else begin
        done_r[0] <= 1'b0;
        q_r[0]    <= '0;
      end
    end
  end

  for (genvar i = 1; i <= FB; i++) begin : g_step
    logic [MW-1:0] r2;
    logic          ge;
    assign r2 = {r_r[i-1][MW-2:0], 1'b0};
    assign ge = r2 >= d_r[i-1];
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[i]    <= d_r[i-1];
        done_r[i] <= done_r[i-1];
        if (done_r[i-1]) begin
          r_r[i] <= r_r[i-1];
          q_r[i] <= q_r[i-1];
        end else begin
          r_r[i] <= ge ? r2 - d_r[i-1] : r2;
          q_r[i] <= {q_r[i-1][QW-2:0], ge};
        end
      end
    end
  end

  assign q = q_r[FB];
endmodule

/* rtl/core/segment_segment_closest_offset_core.sv */
// Closest-point offset between two 3D segments. One segment pair per cycle is
// accepted; the pipeline has eight stages for differences, dot products, the
// 72-bit determinant products and the clamping rules, FRAC_BITS+1 stages for the
// two parallel divider chains, and two for the offset assembly. Output is the
// Q.16 vector from the closest point on B to the closest point on A. The whole
// pipeline stalls while a result beat waits with out_tready low.
module segment_segment_closest_offset_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
  // b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z
  input  logic [ssco_pkg::IN_BITS-1:0]      in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // offset_x, offset_y, offset_z, zero pad
  output logic [ssco_pkg::OUT_BITS-1:0]     out_tdata
);
  localparam int CW   = ssco_pkg::COORD_WIDTH;
  localparam int DW   = ssco_pkg::DW;
  localparam int PW   = ssco_pkg::PW;
  localparam int SW   = ssco_pkg::SW;
  localparam int MW   = ssco_pkg::MW;
  localparam int QW   = ssco_pkg::QW;
  localparam int FB   = ssco_pkg::FRAC_BITS;
  localparam int OW   = ssco_pkg::OUT_WIDTH;
  localparam int UD   = ssco_pkg::UD;
  localparam int NSTG = ssco_pkg::NSTG;
  localparam int RW   = DW + QW + 2;

  logic en;
  logic vld_r [NSTG];

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < NSTG; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // difference vectors
  ssco_pkg::uvw_t uvw_r;
  ssco_pkg::uvw_t uvw_d_r [UD];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        uvw_r.u[i] <= DW'($signed(in_tdata[CW*(3+i) +: CW]))
                    - DW'($signed(in_tdata[CW*i +: CW]));
        uvw_r.v[i] <= DW'($signed(in_tdata[CW*(9+i) +: CW]))
                    - DW'($signed(in_tdata[CW*(6+i) +: CW]));
        uvw_r.w[i] <= DW'($signed(in_tdata[CW*i +: CW]))
                    - DW'($signed(in_tdata[CW*(6+i) +: CW]));
      end
      uvw_d_r[0] <= uvw_r;
      for (int k = 1; k < UD; k++) uvw_d_r[k] <= uvw_d_r[k-1];
    end
  end

  // element products
  logic signed [PW-1:0] puu_r [3];
  logic signed [PW-1:0] puv_r [3];
  logic signed [PW-1:0] pvv_r [3];
  logic signed [PW-1:0] puw_r [3];
  logic signed [PW-1:0] pvw_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        puu_r[i] <= $signed(uvw_r.u[i]) * $signed(uvw_r.u[i]);
        puv_r[i] <= $signed(uvw_r.u[i]) * $signed(uvw_r.v[i]);
        pvv_r[i] <= $signed(uvw_r.v[i]) * $signed(uvw_r.v[i]);
        puw_r[i] <= $signed(uvw_r.u[i]) * $signed(uvw_r.w[i]);
        pvw_r[i] <= $signed(uvw_r.v[i]) * $signed(uvw_r.w[i]);
      end
    end
  end

  // dot products
  ssco_pkg::dot_t dot_r, dot4_r, dot5_r, dot6_r, dot7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dot_r.a <= SW'(puu_r[0]) + SW'(puu_r[1]) + SW'(puu_r[2]);
      dot_r.b <= SW'(puv_r[0]) + SW'(puv_r[1]) + SW'(puv_r[2]);
      dot_r.c <= SW'(pvv_r[0]) + SW'(pvv_r[1]) + SW'(pvv_r[2]);
      dot_r.d <= SW'(puw_r[0]) + SW'(puw_r[1]) + SW'(puw_r[2]);
      dot_r.e <= SW'(pvw_r[0]) + SW'(pvw_r[1]) + SW'(pvw_r[2]);
      dot4_r  <= dot_r;
      dot5_r  <= dot4_r;
      dot6_r  <= dot5_r;
      dot7_r  <= dot6_r;
    end
  end

  logic signed [MW-1:0] ac, bb, be, cd, ae, bd;

  ssco_mul u_mul_ac (.clk(clk), .en(en), .a(dot_r.a), .b(dot_r.c), .p(ac));
  ssco_mul u_mul_bb (.clk(clk), .en(en), .a(dot_r.b), .b(dot_r.b), .p(bb));
  ssco_mul u_mul_be (.clk(clk), .en(en), .a(dot_r.b), .b(dot_r.e), .p(be));
  ssco_mul u_mul_cd (.clk(clk), .en(en), .a(dot_r.c), .b(dot_r.d), .p(cd));
  ssco_mul u_mul_ae (.clk(clk), .en(en), .a(dot_r.a), .b(dot_r.e), .p(ae));
  ssco_mul u_mul_bd (.clk(clk), .en(en), .a(dot_r.b), .b(dot_r.d), .p(bd));

  logic signed [MW-1:0] det_r, sn6_r, tn6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= ac - bb;
      sn6_r <= be - cd;
      tn6_r <= ae - bd;
    end
  end

  // parallel case and s clamp
  ssco_pkg::frac_t f7_nxt, f7_r;

  always_comb begin
    f7_nxt.sn = sn6_r;
    f7_nxt.sd = det_r;
    f7_nxt.tn = tn6_r;
    f7_nxt.td = det_r;
    if (det_r <= 0) begin
      f7_nxt.sn = '0;
      f7_nxt.sd = MW'(1);
      f7_nxt.tn = MW'(dot6_r.e);
      f7_nxt.td = MW'(dot6_r.c);
    end else if (sn6_r < 0) begin
      f7_nxt.sn = '0;
      f7_nxt.tn = MW'(dot6_r.e);
      f7_nxt.td = MW'(dot6_r.c);
    end else if (sn6_r > det_r) begin
      f7_nxt.sn = det_r;
      f7_nxt.tn = MW'(dot6_r.e) + MW'(dot6_r.b);
      f7_nxt.td = MW'(dot6_r.c);
    end
  end

  always_ff @(posedge clk) begin
    if (en) f7_r <= f7_nxt;
  end

  // t clamp and s recompute
  ssco_pkg::frac_t f8_nxt, f8_r;
  logic signed [MW-1:0] nd, bmd, aw;

  always_comb begin
    nd     = -MW'(dot7_r.d);
    bmd    = MW'(dot7_r.b) - MW'(dot7_r.d);
    aw     = MW'(dot7_r.a);
    f8_nxt = f7_r;
    if (f7_r.tn < 0) begin
      f8_nxt.tn = '0;
      if (nd < 0) begin
        f8_nxt.sn = '0;
      end else if (nd > aw) begin
        f8_nxt.sn = f7_r.sd;
      end else begin
        f8_nxt.sn = nd;
        f8_nxt.sd = aw;
      end
    end else if (f7_r.tn > f7_r.td) begin
      f8_nxt.tn = f7_r.td;
      if (bmd < 0) begin
        f8_nxt.sn = '0;
      end else if (bmd > aw) begin
        f8_nxt.sn = f7_r.sd;
      end else begin
        f8_nxt.sn = bmd;
        f8_nxt.sd = aw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) f8_r <= f8_nxt;
  end

  logic [QW-1:0] sc, tc;

  ssco_div u_div_s (.clk(clk), .en(en), .num(f8_r.sn), .den(f8_r.sd), .q(sc));
  ssco_div u_div_t (.clk(clk), .en(en), .num(f8_r.tn), .den(f8_r.td), .q(tc));

  // offset assembly
  logic signed [RW-1:0] us_r [3];
  logic signed [RW-1:0] vt_r [3];
  logic signed [DW-1:0] wq_r [3];
  logic [OW-1:0]        off_r [3];
  logic signed [RW+FB:0] off_full [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        us_r[i] <= $signed(uvw_d_r[UD-1].u[i]) * $signed({1'b0, sc});
        vt_r[i] <= $signed(uvw_d_r[UD-1].v[i]) * $signed({1'b0, tc});
        wq_r[i] <= $signed(uvw_d_r[UD-1].w[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off_full[i] = ((RW+FB+1)'(wq_r[i]) <<< FB) + (RW+FB+1)'(us_r[i])
                  - (RW+FB+1)'(vt_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) off_r[i] <= off_full[i][OW-1:0];
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {(ssco_pkg::OUT_BITS - 3*OW)'(0), off_r[2], off_r[1], off_r[0]};
endmodule

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ssco_pkg::IN_BITS-1:0] pair;
    bit                           drain;
  } beat_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [ssco_pkg::IN_BITS-1:0]  in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [ssco_pkg::OUT_BITS-1:0] out_tdata;

  beat_t               pair_q[$];
  logic [107:0]        offset_q[$];
  int                  errors = 0;
  int                  in_gap = 0;
  int                  out_gap = 0;
  bit                  in_took = 1'b0;
  bit                  in_burst = 1'b0;
  bit                  out_burst = 1'b0;
  longint              cycles = 0;

  segment_segment_closest_offset_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic signed [127:0] frac_quot(logic signed [127:0] num,
                                                   logic signed [127:0] den);
    logic signed [127:0] q;
    q = '0;
    if (num <= 0 || den <= 0) return '0;
    if (num >= den) return 128'sd1 <<< ssco_pkg::FRAC_BITS;
    for (int i = 0; i < ssco_pkg::FRAC_BITS; i++) begin
      num = num <<< 1;
      q = q <<< 1;
      if (num >= den) begin
        num = num - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [107:0] closest_offset(logic [ssco_pkg::IN_BITS-1:0] p);
    longint u[3], v[3], w[3];
    longint as_, ae, bs, be, a, b, c, d, e, sc, tc, r;
    logic signed [127:0] a1, b1, c1, d1, e1, big_d, sn, sd, tn, td;
    logic [107:0] res;
    a = 0; b = 0; c = 0; d = 0; e = 0;
    for (int i = 0; i < 3; i++) begin
      as_ = longint'($signed(p[16*i +: 16]));
      ae  = longint'($signed(p[16*(3+i) +: 16]));
      bs  = longint'($signed(p[16*(6+i) +: 16]));
      be  = longint'($signed(p[16*(9+i) +: 16]));
      u[i] = ae - as_;
      v[i] = be - bs;
      w[i] = as_ - bs;
    end
    for (int i = 0; i < 3; i++) begin
      a += u[i] * u[i];
      b += u[i] * v[i];
      c += v[i] * v[i];
      d += u[i] * w[i];
      e += v[i] * w[i];
    end
    a1 = a; b1 = b; c1 = c; d1 = d; e1 = e;
    big_d = a1 * c1 - b1 * b1;
    sd = big_d;
    td = big_d;
    if (big_d <= 0) begin
      sn = '0; sd = 128'sd1; tn = e1; td = c1;
    end else begin
      sn = b1 * e1 - c1 * d1;
      tn = a1 * e1 - b1 * d1;
      if (sn < 0) begin
        sn = '0; tn = e1; td = c1;
      end else if (sn > sd) begin
        sn = sd; tn = e1 + b1; td = c1;
      end
    end
    if (tn < 0) begin
      tn = '0;
      if (-d < 0) sn = '0;
      else if (-d > a) sn = sd;
      else begin
        sn = -d1; sd = a1;
      end
    end else if (tn > td) begin
      tn = td;
      if (b - d < 0) sn = '0;
      else if (b - d > a) sn = sd;
      else begin
        sn = b1 - d1; sd = a1;
      end
    end
    sc = longint'(frac_quot(sn, sd));
    tc = longint'(frac_quot(tn, td));
    for (int i = 0; i < 3; i++) begin
      r = w[i] * (64'sd1 <<< ssco_pkg::FRAC_BITS) + u[i] * sc - v[i] * tc;
      res[36*i +: 36] = r[35:0];
    end
    return res;
  endfunction

  function automatic int draw_gap(bit burst);
    return burst ? 0 : int'($urandom_range(0, 10));
  endfunction

  task automatic report_mismatch(string what, logic [35:0] got, logic [35:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
  endtask

  task automatic push_pair(input int p[12], input bit drain);
    beat_t bt;
    for (int i = 0; i < 12; i++) bt.pair[16*i +: 16] = p[i][15:0];
    bt.drain = drain;
    pair_q.push_back(bt);
  endtask

  // driver
  always @(negedge clk) begin
    bit nv;
    if (rst_n) begin
      if (!(in_tvalid && !in_took)) begin
        nv = 1'b0;
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (pair_q.size() > 0 &&
                     !(pair_q[0].drain && offset_q.size() > 0)) begin
          in_tdata <= pair_q.pop_front().pair;
          nv = 1'b1;
        end
        in_took <= 1'b0;
        in_tvalid <= nv;
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      if ($urandom_range(0, 99) == 0) in_burst <= ~in_burst;
      if ($urandom_range(0, 99) == 0) out_burst <= ~out_burst;
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [107:0] want;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        offset_q.push_back(closest_offset(in_tdata));
        in_took <= 1'b1;
        in_gap <= draw_gap(in_burst);
      end
      if (out_tvalid && out_tready) begin
        out_gap <= draw_gap(out_burst);
        if (offset_q.size() == 0) begin
          errors++;
          $display("unexpected result beat");
        end else begin
          want = offset_q.pop_front();
          if (out_tdata[35:0] !== want[35:0])
            report_mismatch("offset_x", out_tdata[35:0], want[35:0]);
          if (out_tdata[71:36] !== want[71:36])
            report_mismatch("offset_y", out_tdata[71:36], want[71:36]);
          if (out_tdata[107:72] !== want[107:72])
            report_mismatch("offset_z", out_tdata[107:72], want[107:72]);
        end
      end
    end
    if (cycles > 300000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int p[12];
    int kind, k, base;
    push_pair('{0,0,0, 0,0,0, 0,0,0, 0,0,0}, 1'b0);
    push_pair('{32767,32767,32767, 32767,32767,32767, 32767,32767,32767,
                32767,32767,32767}, 1'b0);
    push_pair('{-32768,-32768,-32768, -32768,-32768,-32768, -32768,-32768,-32768,
                -32768,-32768,-32768}, 1'b0);
    push_pair('{-32768,-32768,-32768, 32767,32767,32767, 32767,-32768,32767,
                -32768,32767,-32768}, 1'b0);
    push_pair('{-32768,32767,-32768, 32767,-32768,32767, -32768,-32768,32767,
                32767,32767,-32768}, 1'b0);
    // parallel, antiparallel, overlapping
    push_pair('{0,0,0, 100,0,0, 0,5,0, 100,5,0}, 1'b0);
    push_pair('{0,0,0, 100,0,0, 50,5,0, 300,5,0}, 1'b0);
    push_pair('{0,0,0, 100,0,0, 100,-7,3, 0,-7,3}, 1'b0);
    push_pair('{0,0,0, 100,0,0, -300,5,0, -200,5,0}, 1'b0);
    // zero-length segments
    push_pair('{7,-3,9, 7,-3,9, 0,0,0, 40,10,-5}, 1'b0);
    push_pair('{0,0,0, 40,10,-5, 7,-3,9, 7,-3,9}, 1'b0);
    push_pair('{7,-3,9, 7,-3,9, -2,5,1, -2,5,1}, 1'b0);
    // skew, interior and clamped on each side
    push_pair('{0,0,0, 10,0,0, 5,-5,3, 5,5,3}, 1'b0);
    push_pair('{0,0,0, 10,0,0, 20,-5,0, 20,5,1}, 1'b0);
    push_pair('{0,0,0, 10,0,0, -20,-5,0, -20,5,1}, 1'b0);
    push_pair('{0,0,0, 10,0,0, 5,20,3, 5,30,3}, 1'b0);
    push_pair('{0,0,0, 10,0,0, 5,-30,3, 5,-20,3}, 1'b0);
    push_pair('{0,0,0, 3,1,0, 30,-40,7, -20,40,-9}, 1'b0);
    for (int n = 0; n < 940; n++) begin
      kind = $urandom_range(0, 9);
      base = $urandom_range(0, 60000) - 30000;
      for (int i = 0; i < 12; i++) begin
        case (kind)
          0, 1, 2, 3, 4: p[i] = int'($urandom_range(0, 65535)) - 32768;
          5, 6:          p[i] = base + int'($urandom_range(0, 200)) - 100;
          9: begin
            case ($urandom_range(0, 3))
              0: p[i] = -32768;
              1: p[i] = 32767;
              2: p[i] = 0;
              default: p[i] = int'($urandom_range(0, 65535)) - 32768;
            endcase
          end
          default:       p[i] = int'($urandom_range(0, 2000)) - 1000;
        endcase
      end
      if (kind == 7) begin
        k = int'($urandom_range(0, 8)) - 4;
        for (int i = 0; i < 3; i++) p[9+i] = p[6+i] + k * (p[3+i] - p[i]);
      end else if (kind == 8) begin
        k = $urandom_range(0, 1) ? 0 : 6;
        for (int i = 0; i < 3; i++) p[k+3+i] = p[k+i];
      end
      push_pair(p, n == 470);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (pair_q.size() != 0 || in_tvalid || offset_q.size() != 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && offset_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/core/ssco_pkg.sv
rtl/core/ssco_mul.sv
rtl/core/ssco_div.sv
rtl/core/segment_segment_closest_offset_core.sv
verif/tb.sv
